// ----- sv/utilization_window_monitor_unit_macros.svh -----
// Assertion helpers for the utilization window monitor
`ifndef UTILIZATION_WINDOW_MONITOR_UNIT_MACROS_SVH
`define UTILIZATION_WINDOW_MONITOR_UNIT_MACROS_SVH
// property that must hold every cycle outside reset
`define UWM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// implication whose consequent is checked in the cycle after the antecedent
`define UWM_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);
`endif

// ----- sv/uwm_pkg.sv -----
`timescale 1ns / 1ps
package uwm_pkg;
   localparam int SAMPLE_W = 14;
   localparam int TIME_W = 48;
   localparam logic [13:0] MAX_UTIL = 14'd10000;
   localparam logic [13:0] CRIT_LEVEL = 14'd9500;
   localparam logic [13:0] LOW_LEVEL = 14'd500;
   localparam logic [47:0] WIN_1MIN = 48'd60000;
   localparam logic [47:0] WIN_5MIN = 48'd300000;
   localparam logic [47:0] ALERT_GAP = 48'd60000;
   localparam logic [9:0] MS_PER_S = 10'd1000;
   localparam logic [1:0] CSR_BORROW = 2'd0;
   localparam logic [1:0] CSR_LEND = 2'd1;
   localparam logic [1:0] CSR_SUSTAIN = 2'd2;
   localparam logic [1:0] ALERT_NONE = 2'd0;
   localparam logic [1:0] ALERT_CRIT = 2'd1;
   localparam logic [1:0] ALERT_LOW = 2'd2;

   typedef struct packed {
      logic [3:0]  class_index;
      logic        class_enabled;
      logic [13:0] util_sample;
      logic [47:0] now_ms;
      logic        cooldown_idle;
   } req_type;

   typedef struct packed {
      logic [3:0]  out_class;
      logic [13:0] short_mean;
      logic [13:0] short_peak;
      logic [13:0] long_mean;
      logic [13:0] long_peak;
      logic        sustained_high;
      logic        sustained_low;
      logic        borrow_ok;
      logic        lend_ok;
      logic [1:0]  alert_kind;
   } rsp_type;

   // divider control; divisor covers counts up to 2047 entries
   typedef struct packed {
      logic        start;
      logic [23:0] dividend;
      logic [10:0] divisor;
   } div_cmd_type;
endpackage

// ----- sv/uwm_ram.sv -----
`timescale 1ns / 1ps
module uwm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ----- sv/uwm_div.sv -----
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle
module uwm_div (
   input  logic                    clock,
   input  logic                    reset,
   input  uwm_pkg::div_cmd_type    cmd,
   output logic                    done,
   output logic [13:0]             quotient
);
   import uwm_pkg::*;
   logic [23:0] quo_ff, quo_in;
   logic [11:0] rem_ff, rem_in;
   logic [10:0] dvs_ff, dvs_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [11:0] trial;

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {rem_ff[10:0], quo_ff[23]} - {1'b0, dvs_ff};
      if (cmd.start) begin
         quo_in = cmd.dividend;
         rem_in = '0;
         dvs_in = cmd.divisor;
         cnt_in = 5'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial[11]) begin
            rem_in = {rem_ff[10:0], quo_ff[23]};
            quo_in = {quo_ff[22:0], 1'b0};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[22:0], 1'b1};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd23) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done = done_ff;
   assign quotient = quo_ff[13:0];
endmodule

// ----- sv/utilization_window_monitor_unit.sv -----
`timescale 1ns / 1ps
// channel | dir | handshake         | payload
// req     | in  | req_valid/ready   | req_data  (uwm_pkg::req_type)
// rsp     | out | rsp_valid/ready   | rsp_data  (uwm_pkg::rsp_type)
// csr     | in  | csr_write_enable  | csr_index, csr_write_data
// One sample at a time: write, then a window walk and a sustain walk over up to n
// entries each (n = stored entries with the new one), then two divisions.
// Disabled or out-of-range beats drop with no result.
// Reset is synchronous; rings need no clearing, fill counts guard reads.
// req_ready is low from the accept of an enabled, in-range beat until its result
// beat is taken.
module utilization_window_monitor_unit #(
   parameter int CLASSES = 16,
   parameter int HISTORY_DEPTH = 512
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  uwm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output uwm_pkg::rsp_type rsp_data,
   input  logic             csr_write_enable,
   input  logic [1:0]       csr_index,
   input  logic [8:0]       csr_write_data
);
   import uwm_pkg::*;
   `include "utilization_window_monitor_unit_macros.svh"

   localparam int SW = $clog2(HISTORY_DEPTH);
   localparam int CW = (CLASSES > 1) ? $clog2(CLASSES) : 1;
   localparam int AW = CW + SW;
   localparam int NW = $clog2(HISTORY_DEPTH + 1);
   localparam logic [SW-1:0] LAST_SLOT = SW'(HISTORY_DEPTH - 1);
   localparam logic [NW-1:0] DEPTH_N = NW'(HISTORY_DEPTH);

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b0000000001,
      ST_WRITE = 10'b0000000010,
      ST_WALK1 = 10'b0000000100,
      ST_PREP2 = 10'b0000001000,
      ST_WALK2 = 10'b0000010000,
      ST_DIV1  = 10'b0000100000,
      ST_WAIT1 = 10'b0001000000,
      ST_DIV5  = 10'b0010000000,
      ST_WAIT5 = 10'b0100000000,
      ST_OUT   = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   logic [6:0] borrow_ff, lend_ff;
   logic [8:0] sustain_ff;
   logic [SW-1:0] wslot_ff [CLASSES];
   logic [NW-1:0] fill_ff [CLASSES];
   logic [47:0]   alert_ms_ff [CLASSES];

   logic [CW-1:0] cls_ff;
   logic [13:0] u_ff;
   logic [47:0] now_ff;
   logic idle_ff;
   logic [SW-1:0] newest_ff;
   logic [NW-1:0] n_ff;
   // issue counter for the pipelined walk
   logic [NW-1:0] iss_ff;
   logic pend_ff, pend2_ff;
   logic stop_ff, hiop_ff, loop_ff;
   logic [23:0] sum1_ff, sum5_ff;
   logic [10:0] cnt1_ff, cnt5_ff;
   logic [13:0] max1_ff, max5_ff;
   logic [NW-1:0] runh_ff, runl_ff;
   logic [13:0] avg1_ff;
   logic [1:0]  alert_ff;
   logic [47:0] span_ff;
   logic [13:0] hthr_ff, lthr_ff;
   rsp_type rsp_ff;
   logic rspv_ff;

   logic [13:0] rd_s;
   logic [47:0] rd_t;
   logic [SW-1:0] rd_slot;
   div_cmd_type dcmd;
   logic ddone;
   logic [13:0] dq;
   logic [13:0] u_sat;
   logic req_fire;
   // time sums carry one extra bit so they never wrap
   logic [48:0] t_win5, t_win1, t_span, alert_due;
   logic alert_hit;

   assign u_sat = (req_data.util_sample > MAX_UTIL) ? MAX_UTIL : req_data.util_sample;
   assign req_ready = (state_ff == ST_IDLE) && !rspv_ff;
   assign req_fire = req_valid && req_ready;
   // ring slot of the entry iss_ff steps back from the newest
   assign rd_slot = (NW'(newest_ff) >= iss_ff) ? SW'(NW'(newest_ff) - iss_ff) :
                    SW'(NW'(newest_ff) + DEPTH_N - iss_ff);

   assign t_win5 = {1'b0, rd_t} + {1'b0, WIN_5MIN};
   assign t_win1 = {1'b0, rd_t} + {1'b0, WIN_1MIN};
   assign t_span = {1'b0, rd_t} + {1'b0, span_ff};
   assign alert_due = {1'b0, alert_ms_ff[cls_ff]} + {1'b0, ALERT_GAP};
   assign alert_hit = (u_ff >= CRIT_LEVEL || u_ff <= LOW_LEVEL) &&
                      ({1'b0, now_ff} >= alert_due);

   uwm_ram #(.WIDTH(SAMPLE_W), .DEPTH(2 ** AW)) u_samples (
      .clock(clock), .wr_en(state_ff == ST_WRITE), .wr_addr({cls_ff, newest_ff}),
      .wr_data(u_ff), .rd_addr(AW'({cls_ff, rd_slot})), .rd_data(rd_s));
   uwm_ram #(.WIDTH(TIME_W), .DEPTH(2 ** AW)) u_times (
      .clock(clock), .wr_en(state_ff == ST_WRITE), .wr_addr({cls_ff, newest_ff}),
      .wr_data(now_ff), .rd_addr(AW'({cls_ff, rd_slot})), .rd_data(rd_t));

   uwm_div u_div (.clock(clock), .reset(reset), .cmd(dcmd), .done(ddone), .quotient(dq));

   always_comb begin
      dcmd.start = (state_ff == ST_DIV1) || (state_ff == ST_DIV5);
      dcmd.dividend = (state_ff == ST_DIV1) ? sum1_ff : sum5_ff;
      dcmd.divisor = (state_ff == ST_DIV1) ? cnt1_ff : cnt5_ff;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_fire && req_data.class_enabled &&
                        32'(req_data.class_index) < CLASSES) state_in = ST_WRITE;
         ST_WRITE: state_in = ST_WALK1;
         ST_WALK1: if (!pend2_ff && !pend_ff && (stop_ff || iss_ff >= n_ff))
                      state_in = ST_PREP2;
         ST_PREP2: state_in = ST_WALK2;
         ST_WALK2: if (!pend2_ff && !pend_ff &&
                        (!(hiop_ff || loop_ff) || iss_ff >= n_ff || n_ff < NW'(sustain_ff)))
                      state_in = ST_DIV1;
         ST_DIV1:  state_in = ST_WAIT1;
         ST_WAIT1: if (ddone) state_in = ST_DIV5;
         ST_DIV5:  state_in = ST_WAIT5;
         ST_WAIT5: if (ddone) state_in = ST_OUT;
         ST_OUT:   state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   logic issue;
   logic in_s;
   always_comb begin
      issue = 1'b0;
      if (state_ff == ST_WALK1) issue = !stop_ff && iss_ff < n_ff;
      if (state_ff == ST_WALK2)
         issue = (hiop_ff || loop_ff) && iss_ff < n_ff && n_ff >= NW'(sustain_ff);
      in_s = !(rd_t > now_ff) && !(t_span < {1'b0, now_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         borrow_ff <= 7'd90;
         lend_ff <= 7'd30;
         sustain_ff <= 9'd5;
         rspv_ff <= 1'b0;
         pend_ff <= 1'b0;
         pend2_ff <= 1'b0;
         for (int c = 0; c < CLASSES; c++) begin
            wslot_ff[c] <= '0;
            fill_ff[c] <= '0;
            alert_ms_ff[c] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_BORROW:  borrow_ff <= csr_write_data[6:0];
               CSR_LEND:    lend_ff <= csr_write_data[6:0];
               CSR_SUSTAIN: sustain_ff <= csr_write_data;
               default: ;
            endcase
         end
         // read data returns in the cycle after issue; track it two deep
         pend_ff <= issue;
         pend2_ff <= pend_ff;
         if (rspv_ff && rsp_ready) rspv_ff <= 1'b0;
         if (state_ff == ST_OUT) rspv_ff <= 1'b1;
         if (state_ff == ST_WRITE) begin
            wslot_ff[cls_ff] <= (newest_ff == LAST_SLOT) ? '0 : newest_ff + 1'b1;
            if (fill_ff[cls_ff] < DEPTH_N) fill_ff[cls_ff] <= fill_ff[cls_ff] + 1'b1;
         end
         if (state_ff == ST_WRITE && alert_hit)
            alert_ms_ff[cls_ff] <= now_ff;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (req_fire) begin
         cls_ff <= CW'(req_data.class_index);
         u_ff <= u_sat;
         now_ff <= req_data.now_ms;
         idle_ff <= req_data.cooldown_idle;
         newest_ff <= wslot_ff[CW'(req_data.class_index)];
         n_ff <= (fill_ff[CW'(req_data.class_index)] < DEPTH_N) ?
                 fill_ff[CW'(req_data.class_index)] + 1'b1 : DEPTH_N;
         iss_ff <= '0;
         stop_ff <= 1'b0;
         sum1_ff <= '0; sum5_ff <= '0; cnt1_ff <= '0; cnt5_ff <= '0;
         max1_ff <= '0; max5_ff <= '0;
      end
      if (state_ff == ST_WRITE) begin
         alert_ff <= !alert_hit ? ALERT_NONE :
                     (u_ff >= CRIT_LEVEL) ? ALERT_CRIT : ALERT_LOW;
         span_ff <= 48'(sustain_ff) * 48'(MS_PER_S);
         hthr_ff <= 14'(borrow_ff) * 14'd100;
         lthr_ff <= 14'(lend_ff) * 14'd100;
      end
      if (issue) iss_ff <= iss_ff + 1'b1;
      // window walk: data valid the cycle after issue (pend)
      if (state_ff == ST_WALK1 && pend_ff && !stop_ff) begin
         if (t_win5 < {1'b0, now_ff}) begin
            stop_ff <= 1'b1;
         end else begin
            sum5_ff <= sum5_ff + 24'(rd_s);
            cnt5_ff <= cnt5_ff + 1'b1;
            if (rd_s > max5_ff) max5_ff <= rd_s;
            if (t_win1 >= {1'b0, now_ff}) begin
               sum1_ff <= sum1_ff + 24'(rd_s);
               cnt1_ff <= cnt1_ff + 1'b1;
               if (rd_s > max1_ff) max1_ff <= rd_s;
            end
         end
      end
      if (state_ff == ST_PREP2) begin
         iss_ff <= '0;
         hiop_ff <= 1'b1; loop_ff <= 1'b1;
         runh_ff <= '0; runl_ff <= '0;
      end
      if (state_ff == ST_WALK2 && pend_ff && in_s) begin
         if (hiop_ff) begin
            if (rd_s >= hthr_ff) runh_ff <= runh_ff + 1'b1; else hiop_ff <= 1'b0;
         end
         if (loop_ff) begin
            if (rd_s <= lthr_ff) runl_ff <= runl_ff + 1'b1; else loop_ff <= 1'b0;
         end
      end
      if (state_ff == ST_WAIT1 && ddone) avg1_ff <= dq;
      if (state_ff == ST_OUT) begin
         rsp_ff.out_class <= 4'(cls_ff);
         rsp_ff.short_mean <= avg1_ff;
         rsp_ff.short_peak <= max1_ff;
         rsp_ff.long_mean <= dq;
         rsp_ff.long_peak <= max5_ff;
         rsp_ff.sustained_high <= (n_ff >= NW'(sustain_ff)) && runh_ff >= NW'(sustain_ff);
         rsp_ff.sustained_low <= (n_ff >= NW'(sustain_ff)) && runl_ff >= NW'(sustain_ff);
         rsp_ff.borrow_ok <= (n_ff >= NW'(sustain_ff)) && runh_ff >= NW'(sustain_ff) &&
                             idle_ff;
         rsp_ff.lend_ok <= (n_ff >= NW'(sustain_ff)) && runl_ff >= NW'(sustain_ff) &&
                           idle_ff;
         rsp_ff.alert_kind <= alert_ff;
      end
   end

   assign rsp_valid = rspv_ff;
   assign rsp_data = rsp_ff;

   `UWM_ASSERT(a_no_accept_busy, !(req_ready && rspv_ff), "accept while result pending")
   `UWM_ASSERT_NEXT(a_out_valid, state_ff == ST_OUT, rspv_ff, "result not raised")
   `UWM_ASSERT(a_one_state, $onehot(state_ff), "state not one-hot")
endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
   import uwm_pkg::*;

   localparam int NCLS = 16;
   localparam int DEPTH = 512;
   localparam int LIMIT = 3000000;
   localparam int DRAIN = 1200;

   logic clock;
   logic reset;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_write_enable = 1'b0;
   logic [1:0] csr_index = CSR_BORROW;
   logic [8:0] csr_write_data = '0;

   utilization_window_monitor_unit u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   // shadow of the per-class history and settings
   logic [13:0] hist_util [NCLS][DEPTH];
   logic [63:0] hist_time [NCLS][DEPTH];
   int slot_of [NCLS];
   int fill_of [NCLS];
   logic [63:0] alert_at [NCLS];
   int borrow_pct = 90;
   int lend_pct = 30;
   int sustain_s = 5;

   req_type sample_queue[$];
   rsp_type stats_expected[$];
   int errors = 0;
   int cycles = 0;
   logic req_taken = 1'b0;

   // stimulus shaping state
   logic [63:0] class_clock [NCLS];
   int class_mode [NCLS];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report(input string msg);
      $display("mismatch: %s", msg);
      errors++;
   endtask

   task automatic check_field(input string name, input longint unsigned got,
                              input longint unsigned want);
      if (got !== want)
         report($sformatf("%s got %0d want %0d", name, got, want));
   endtask

   // window stats, sustain runs and alerts for one accepted sample
   function automatic bit predict_stats(input req_type r, output rsp_type e);
      int c, n, idx, i;
      logic [13:0] u, v;
      logic [63:0] now, t, span, sum1, sum5;
      int cnt1, cnt5, max1, max5, run_hi, run_lo, hi_thr, lo_thr;
      bit hi_open, lo_open, hi, lo;
      logic [1:0] alert;
      e = '0;
      if (!r.class_enabled) return 1'b0;
      c = r.class_index;
      u = (r.util_sample > MAX_UTIL) ? MAX_UTIL : r.util_sample;
      now = {16'd0, r.now_ms};
      hist_util[c][slot_of[c]] = u;
      hist_time[c][slot_of[c]] = now;
      slot_of[c] = (slot_of[c] + 1) % DEPTH;
      if (fill_of[c] < DEPTH) fill_of[c]++;
      n = fill_of[c];
      sum1 = 0; sum5 = 0; cnt1 = 0; cnt5 = 0; max1 = 0; max5 = 0;
      for (i = 0; i < n; i++) begin
         idx = (slot_of[c] + DEPTH - 1 - i) % DEPTH;
         t = hist_time[c][idx];
         v = hist_util[c][idx];
         if (t + 64'(WIN_5MIN) < now) break;
         sum5 += v; cnt5++;
         if (v > max5) max5 = v;
         if (t + 64'(WIN_1MIN) >= now) begin
            sum1 += v; cnt1++;
            if (v > max1) max1 = v;
         end
      end
      hi = 1'b0; lo = 1'b0;
      if (n >= sustain_s) begin
         span = 64'(sustain_s) * 64'd1000;
         hi_thr = borrow_pct * 100;
         lo_thr = lend_pct * 100;
         run_hi = 0; run_lo = 0; hi_open = 1'b1; lo_open = 1'b1;
         for (i = 0; i < n && (hi_open || lo_open); i++) begin
            idx = (slot_of[c] + DEPTH - 1 - i) % DEPTH;
            t = hist_time[c][idx];
            v = hist_util[c][idx];
            if (t > now || t + span < now) continue;
            if (hi_open) begin
               if (v >= hi_thr) run_hi++; else hi_open = 1'b0;
            end
            if (lo_open) begin
               if (v <= lo_thr) run_lo++; else lo_open = 1'b0;
            end
         end
         hi = run_hi >= sustain_s;
         lo = run_lo >= sustain_s;
      end
      alert = ALERT_NONE;
      if ((u >= CRIT_LEVEL || u <= LOW_LEVEL) && now >= alert_at[c] + 64'(ALERT_GAP)) begin
         alert = (u >= CRIT_LEVEL) ? ALERT_CRIT : ALERT_LOW;
         alert_at[c] = now;
      end
      e.out_class = r.class_index;
      e.short_mean = 14'(sum1 / cnt1);
      e.short_peak = 14'(max1);
      e.long_mean = 14'(sum5 / cnt5);
      e.long_peak = 14'(max5);
      e.sustained_high = hi;
      e.sustained_low = lo;
      e.borrow_ok = hi & r.cooldown_idle;
      e.lend_ok = lo & r.cooldown_idle;
      e.alert_kind = alert;
      return 1'b1;
   endfunction

   // monitor: predict on request beats, check on result beats
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         cycles++;
         if (cycles > LIMIT) begin
            $display("utilization_window_monitor_unit verification failed");
            $finish;
         end
         req_taken <= req_valid && req_ready;
         if (req_valid && req_ready && predict_stats(req_data, want))
            stats_expected.push_back(want);
         if (rsp_valid && rsp_ready) begin
            if (stats_expected.size() == 0) begin
               report("result beat with nothing expected");
            end else begin
               want = stats_expected.pop_front();
               check_field("out_class", rsp_data.out_class, want.out_class);
               check_field("short_mean", rsp_data.short_mean, want.short_mean);
               check_field("short_peak", rsp_data.short_peak, want.short_peak);
               check_field("long_mean", rsp_data.long_mean, want.long_mean);
               check_field("long_peak", rsp_data.long_peak, want.long_peak);
               check_field("sustained_high", rsp_data.sustained_high,
                           want.sustained_high);
               check_field("sustained_low", rsp_data.sustained_low, want.sustained_low);
               check_field("borrow_ok", rsp_data.borrow_ok, want.borrow_ok);
               check_field("lend_ok", rsp_data.lend_ok, want.lend_ok);
               check_field("alert_kind", rsp_data.alert_kind, want.alert_kind);
            end
         end
      end
   end

   // sample driver: bursts with random gaps
   int burst_left = 1;
   int gap_left = 0;
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (sample_queue.size() > 0) begin
            req_data <= sample_queue.pop_front();
            req_valid <= 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 20);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result receiver: stall style changes every so often
   int stall_style = 0;
   int stall_count = 0;
   always @(negedge clock) begin
      if (stall_count == 0) begin
         stall_style = $urandom_range(0, 2);
         stall_count = $urandom_range(20, 200);
      end
      stall_count--;
      case (stall_style)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= $urandom_range(0, 1);
         default: rsp_ready <= ($urandom_range(0, 15) == 0);
      endcase
   end

   task automatic write_reg(input logic [1:0] idx, input int val);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= val[8:0];
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic set_regs(input int b, input int l, input int s);
      write_reg(CSR_BORROW, b);
      write_reg(CSR_LEND, l);
      write_reg(CSR_SUSTAIN, s);
      borrow_pct = b;
      lend_pct = l;
      sustain_s = s;
   endtask

   task automatic wait_idle();
      while (sample_queue.size() > 0 || req_valid || stats_expected.size() > 0)
         @(posedge clock);
      // a dropped disabled beat may still be in flight
      repeat (40) @(posedge clock);
   endtask

   task automatic add_sample(input int c, input bit en, input int u,
                             input logic [47:0] t, input bit idle);
      req_type r;
      r.class_index = c[3:0];
      r.class_enabled = en;
      r.util_sample = u[13:0];
      r.now_ms = t;
      r.cooldown_idle = idle;
      sample_queue.push_back(r);
   endtask

   // random traffic; steady streams keep 1 s spacing and one value band
   task automatic gen_traffic(input int count, input int focus, input int spread,
                              input bit wild);
      int c, u, hi_floor, lo_ceil, k;
      logic [63:0] step;
      hi_floor = (borrow_pct * 100 > 10000) ? 10000 : borrow_pct * 100;
      lo_ceil = (lend_pct * 100 > 10000) ? 10000 : lend_pct * 100;
      for (k = 0; k < count; k++) begin
         c = (focus + $urandom_range(0, spread - 1)) % NCLS;
         step = 64'd1000;
         if (wild) begin
            if ($urandom_range(0, 9) == 0) class_mode[c] = $urandom_range(0, 2);
            case ($urandom_range(0, 14))
               0: step = 0;
               1: step = 999;
               2: step = 1001;
               3: step = 60000;
               4: step = 60001;
               5: step = 300000;
               6: step = 300001;
               7: step = $urandom_range(0, 400000);
               8: step = -64'($urandom_range(1, 5000));
               default: step = 64'd1000;
            endcase
         end
         class_clock[c] = (class_clock[c] + step) & 64'hFFFF_FFFF_FFFF;
         case (class_mode[c])
            0: u = $urandom_range(hi_floor, 10000);
            1: u = $urandom_range(0, lo_ceil);
            default: u = $urandom_range(0, 16383);
         endcase
         if (wild && $urandom_range(0, 19) == 0) u = $urandom_range(0, 16383);
         add_sample(c, !(wild && $urandom_range(0, 19) == 0), u,
                    class_clock[c][47:0], $urandom_range(0, 1));
      end
   endtask

   initial begin
      int c;
      for (c = 0; c < NCLS; c++) begin
         slot_of[c] = 0;
         fill_of[c] = 0;
         alert_at[c] = 0;
         class_mode[c] = $urandom_range(0, 2);
         class_clock[c] = (c < 6) ? 64'd0 : {16'd0, $urandom(), $urandom()} >> 16;
      end
      class_clock[15] = 64'hFFFF_FFF0_0000;
      reset = 1'b1;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // directed: value extremes, alert edges, time extremes, disabled beat
      add_sample(0, 1, 0, 48'd0, 1);
      add_sample(0, 1, 16383, 48'd1000, 1);
      add_sample(0, 1, 10000, 48'd2000, 0);
      add_sample(0, 1, 9500, 48'd3000, 1);
      add_sample(0, 1, 9499, 48'd4000, 1);
      add_sample(0, 1, 9999, 48'd5000, 1);
      add_sample(0, 1, 9600, 48'd60000, 1);
      add_sample(0, 1, 9700, 48'd119999, 1);
      add_sample(0, 1, 500, 48'd120000, 1);
      add_sample(0, 1, 501, 48'd180000, 0);
      add_sample(0, 1, 100, 48'd180000, 1);
      add_sample(0, 1, 8000, 48'd479999, 1);
      add_sample(0, 1, 7000, 48'd480000, 1);
      add_sample(0, 0, 5000, 48'd500000, 1);
      add_sample(1, 1, 3000, 48'hFFFF_FFFF_FFFF, 1);
      add_sample(1, 1, 2000, 48'hFFFF_FFFF_0000, 1);
      add_sample(1, 1, 400, 48'hFFFF_FFFF_FFFF, 0);
      add_sample(2, 1, 5555, 48'hAAAA_AAAA_AAAA, 1);
      add_sample(2, 1, 12345, 48'hAAAA_AAAA_AEAA, 1);
      add_sample(3, 1, 0, 48'd0, 1);
      add_sample(3, 1, 0, 48'd1000, 1);
      add_sample(3, 1, 0, 48'd2000, 1);
      add_sample(3, 1, 0, 48'd3000, 1);
      add_sample(3, 1, 0, 48'd4000, 1);
      add_sample(3, 1, 0, 48'd5000, 1);
      wait_idle();

      set_regs(100, 0, 1);
      gen_traffic(60, 4, 4, 1);
      wait_idle();

      // sustain of zero is always met
      set_regs(0, 100, 0);
      gen_traffic(60, 8, 4, 1);
      wait_idle();

      set_regs(50, 50, 3);
      gen_traffic(65, 0, 16, 1);
      wait_idle();

      // longest sustain window on one class with a steady high stream
      set_regs(80, 20, 300);
      class_mode[12] = 0;
      gen_traffic(310, 12, 1, 0);
      wait_idle();

      set_regs(90, 30, 5);
      gen_traffic(60, 2, 6, 1);
      wait_idle();

      repeat (DRAIN) @(posedge clock);
      if (errors == 0 && stats_expected.size() == 0)
         $display("utilization_window_monitor_unit verification clean");
      else
         $display("utilization_window_monitor_unit verification failed");
      $finish;
   end
endmodule

// ----- files.f -----
+incdir+sv
sv/uwm_pkg.sv
sv/uwm_ram.sv
sv/uwm_div.sv
sv/utilization_window_monitor_unit.sv
bench/tb_top.sv
